>>> src/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ESD_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ESD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define ESD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ESD_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ESD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ESD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/esd_pkg.sv
// Types, codes and helpers of the escaped byte decoder.
`default_nettype none

package esd_pkg;

    // decoding position
    localparam logic [1:0] MODE_PLAIN = 2'd0;
    localparam logic [1:0] MODE_ESC   = 2'd1;
    localparam logic [1:0] MODE_HEX0  = 2'd2;
    localparam logic [1:0] MODE_HEX1  = 2'd3;

    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;
    localparam logic [7:0] BYTE_ESC = 8'h1B;

    // group queue between decoder and output
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int FILL_W     = 3;

    // decoded bytes of one input item, data[0] goes out first
    typedef struct packed {
        logic [2:0][7:0] data;
        logic [1:0]      count;
        logic            last;
    } group_t;

    function automatic logic is_hex(input logic [7:0] b);
        return ((b >= CH_0) && (b <= CH_9)) ||
               ((b >= CH_LA) && (b <= CH_LF)) ||
               ((b >= CH_UA) && (b <= CH_UF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        priority if ((b >= CH_0) && (b <= CH_9))
            v = b - CH_0;
        else if ((b >= CH_LA) && (b <= CH_LF))
            v = b - CH_LA + 8'd10;
        else if ((b >= CH_UA) && (b <= CH_UF))
            v = b - CH_UA + 8'd10;
        else
            v = 8'd0;
        return v[3:0];
    endfunction

endpackage

`default_nettype wire

>>> src/esd_if.sv
// Handshake interfaces of the decoder's input and output channels.
`default_nettype none

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

>>> src/esd_decode.sv
// Escape decoding of one byte: result group and next decoding position.
`default_nettype none

module esd_decode (
    input  wire logic [7:0]    in_byte,
    input  wire logic          in_last,
    input  wire logic [1:0]    mode,
    input  wire logic [7:0]    held,
    output esd_pkg::group_t    result,
    output logic [1:0]         mode_next,
    output logic [7:0]         held_next
);

    logic b_hex;
    logic b_bsl;

    assign b_hex = esd_pkg::is_hex(in_byte);
    assign b_bsl = (in_byte == esd_pkg::CH_BSL) && !in_last;

    always_comb
    begin
        result    = '0;
        mode_next = esd_pkg::MODE_PLAIN;
        held_next = held;

        unique case (mode)
            esd_pkg::MODE_PLAIN:
            begin
                if (b_bsl)
                begin
                    mode_next = esd_pkg::MODE_ESC;
                end
                else
                begin
                    result.data[0] = in_byte;
                    result.count   = 2'd1;
                end
            end
            esd_pkg::MODE_ESC:
            begin
                result.count = 2'd1;
                priority if (in_byte == esd_pkg::CH_X)
                begin
                    if (in_last)
                        result.data[0] = esd_pkg::CH_X;
                    else
                    begin
                        result.count = 2'd0;
                        mode_next    = esd_pkg::MODE_HEX0;
                    end
                end
                else if (in_byte == esd_pkg::CH_N)
                    result.data[0] = esd_pkg::BYTE_LF;
                else if (in_byte == esd_pkg::CH_R)
                    result.data[0] = esd_pkg::BYTE_CR;
                else if (in_byte == esd_pkg::CH_T)
                    result.data[0] = esd_pkg::BYTE_TAB;
                else if (in_byte == esd_pkg::CH_E)
                    result.data[0] = esd_pkg::BYTE_ESC;
                else
                    result.data[0] = in_byte;
            end
            esd_pkg::MODE_HEX0:
            begin
                if (b_hex && !in_last)
                begin
                    held_next = in_byte;
                    mode_next = esd_pkg::MODE_HEX1;
                end
                else
                begin
                    // broken x escape: emit x, then the byte as plain text unless it opens a new escape
                    result.data[0] = esd_pkg::CH_X;
                    if (b_bsl)
                    begin
                        result.count = 2'd1;
                        mode_next    = esd_pkg::MODE_ESC;
                    end
                    else
                    begin
                        result.data[1] = in_byte;
                        result.count   = 2'd2;
                    end
                end
            end
            esd_pkg::MODE_HEX1:
            begin
                if (esd_pkg::is_hex(held) && b_hex)
                begin
                    result.data[0] = {esd_pkg::hex_val(held), esd_pkg::hex_val(in_byte)};
                    result.count   = 2'd1;
                end
                else
                begin
                    // held digit is always hex here, so it passes as plain text
                    result.data[0] = esd_pkg::CH_X;
                    result.data[1] = held;
                    if (b_bsl)
                    begin
                        result.count = 2'd2;
                        mode_next    = esd_pkg::MODE_ESC;
                    end
                    else
                    begin
                        result.data[2] = in_byte;
                        result.count   = 2'd3;
                    end
                end
            end
            default:
            begin
                mode_next = esd_pkg::MODE_PLAIN;
            end
        endcase

        if (in_last)
        begin
            mode_next   = esd_pkg::MODE_PLAIN;
            result.last = 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> src/escaped_ssid_byte_decoder_core.sv
// Top level of the escaped byte decoder: state, group queue and output unpacking.
//
// Usage
//   in_ch  : escaped string, one byte per item, in_last on the final byte.
//   out_ch : decoded bytes, one per item, out_last on the final decoded byte
//            of a string.
//   Each accepted byte is decoded in the cycle it is taken; the one to three
//   resulting bytes, if any, go as one group into a four-entry queue. The head
//   group is unpacked onto out_ch one byte a cycle while out_ch.ready is high.
//   Latency: a decoded byte is visible on out_ch the cycle after its input
//   item is accepted (when the queue is otherwise empty).
//   Throughput: one input item per cycle while each gives at most one byte;
//   a group of n bytes goes out on out_ch as n items, and the input is
//   held off only once all four queue entries are full.
//   A string ending mid-escape flushes the held bytes with out_last set.
//   Reset clears the decoding position and empties the queue; out_ch.valid
//   is low during and right after reset.
//   When the receiver stalls, the head byte stays on out_ch unchanged and
//   input items keep being taken until the queue fills.
`default_nettype none

`include "assert_macros.svh"

module escaped_ssid_byte_decoder_core (
    input  wire logic  clk,
    input  wire logic  rst_n,
    esd_in_if.sink     in_ch,
    esd_out_if.source  out_ch
);

    logic [1:0]                  mode_reg;
    logic [1:0]                  mode_next;
    logic [7:0]                  held_reg;
    logic [7:0]                  held_next;

    esd_pkg::group_t             dec_group;
    esd_pkg::group_t             queue_reg [esd_pkg::FIFO_DEPTH];
    esd_pkg::group_t             head;

    logic [esd_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [esd_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [esd_pkg::FILL_W-1:0]  fill_reg;
    logic [esd_pkg::FILL_W-1:0]  fill_next;
    logic [1:0]                  idx_reg;

    logic in_take;
    logic push;
    logic out_take;
    logic head_end;
    logic pop;

    esd_decode u_decode (
        .in_byte   (in_ch.in_byte),
        .in_last   (in_ch.in_last),
        .mode      (mode_reg),
        .held      (held_reg),
        .result    (dec_group),
        .mode_next (mode_next),
        .held_next (held_next)
    );

    // handshakes
    assign in_ch.ready  = (fill_reg != esd_pkg::FILL_W'(esd_pkg::FIFO_DEPTH));
    assign in_take      = in_ch.valid && in_ch.ready;
    assign push         = in_take && (dec_group.count != 2'd0);

    assign head         = queue_reg[rd_ptr_reg];
    assign head_end     = (idx_reg == (head.count - 2'd1));
    assign out_ch.valid = (fill_reg != '0);
    assign out_take     = out_ch.valid && out_ch.ready;
    assign pop          = out_take && head_end;

    assign out_ch.out_byte = head.data[idx_reg];
    assign out_ch.out_last = head.last && head_end;

    always_comb
    begin
        fill_next = fill_reg + esd_pkg::FILL_W'(push) - esd_pkg::FILL_W'(pop);
    end

    // decoding position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_PLAIN;
            held_reg <= 8'd0;
        end
        else if (in_take)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

    // queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            idx_reg    <= 2'd0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + esd_pkg::PTR_W'(1);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + esd_pkg::PTR_W'(1);
                idx_reg    <= 2'd0;
            end
            else if (out_take)
                idx_reg <= idx_reg + 2'd1;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= dec_group;
    end

    `ESD_ASSERT_ALWAYS(a_fill_bound, clk, rst_n,
        fill_reg <= esd_pkg::FILL_W'(esd_pkg::FIFO_DEPTH))
    `ESD_ASSERT_SAME(a_head_nonempty, clk, rst_n, out_ch.valid, head.count != 2'd0)
    `ESD_ASSERT_SAME(a_idx_in_group, clk, rst_n, out_ch.valid, idx_reg < head.count)
    `ESD_ASSERT_SAME(a_held_is_hex, clk, rst_n,
        mode_reg == esd_pkg::MODE_HEX1, esd_pkg::is_hex(held_reg))
    `ESD_ASSERT_NEXT(a_last_resets_mode, clk, rst_n,
        in_take && in_ch.in_last, mode_reg == esd_pkg::MODE_PLAIN)

endmodule

`default_nettype wire
